/* sv/mnpt_pkg.sv */
// Package: shared constants for the mono note priority tracker.
`timescale 1ns / 1ps
`default_nettype none

package mnpt_pkg;

    localparam int NOTE_SLOTS_DEFAULT = 16;
    localparam int NOTE_W             = 7;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 2;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_PRIORITY_SELECT = 2'd0;

    // priority_select codes
    localparam logic PRIO_HIGHEST = 1'b0;
    localparam logic PRIO_LOWEST  = 1'b1;

    // event kinds
    localparam logic MODE_NOTE_OFF = 1'b0;
    localparam logic MODE_NOTE_ON  = 1'b1;

endpackage

`default_nettype wire

/* sv/mono_note_priority_tracker_top.sv */
// An accepted event sweeps every slot in order; done is strobed after the last slot's compare.
// A new event is taken only in idle; busy is high while a sweep runs.
// Each slot sweep step does one note RAM read and one shared compare.
// The result appears on current_note/any_held in the single cycle that done is high and holds until the next done.
// Reset (rst_n low, async) empties all slots, clears current_note and priority_select.
`timescale 1ns / 1ps
`default_nettype none

module mono_note_priority_tracker_top #(
    parameter int NOTE_SLOTS = mnpt_pkg::NOTE_SLOTS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // event command
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                mode,
    input  wire logic [mnpt_pkg::NOTE_W-1:0]         note_number,
    // result
    output logic                                     done,
    output logic      [mnpt_pkg::NOTE_W-1:0]         current_note,
    output logic                                     any_held,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mnpt_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [mnpt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [mnpt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    localparam int IDX_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int CNT_W = $clog2(NOTE_SLOTS + 1);
    localparam int NW    = mnpt_pkg::NOTE_W;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg, state_next;
    logic             valid_reg [NOTE_SLOTS];
    logic             valid_next [NOTE_SLOTS];
    logic             mode_reg, mode_next;
    logic [NW-1:0]    note_reg, note_next;
    logic             found_reg, found_next;
    logic             any_reg, any_next;
    logic [NW-1:0]    best_reg, best_next;
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] proc_idx_reg, proc_idx_next;
    logic [NW-1:0]    chosen_reg, chosen_next;
    logic             prio_reg, prio_next;
    logic             done_reg, done_next;
    logic [NW-1:0]    cur_note_reg, cur_note_next;
    logic             any_held_reg, any_held_next;

    logic             ram_we;
    logic [NW-1:0]    ram_rdata;

    logic             slot_v;
    logic             eff_v;
    logic [NW-1:0]    eff_n;
    logic             better;
    logic             scan_any;
    logic [NW-1:0]    scan_best;
    logic             apb_write;

    mnpt_ram #(
        .WIDTH (NW),
        .DEPTH (NOTE_SLOTS),
        .ADDR_W(IDX_W)
    ) u_note_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(proc_idx_reg),
        .wdata(note_reg),
        .raddr(issue_idx_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    assign apb_write = psel && penable && pwrite;

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        mode_next      = mode_reg;
        note_next      = note_reg;
        found_next     = found_reg;
        any_next       = any_reg;
        best_next      = best_reg;
        issue_idx_next = issue_idx_reg;
        pend_next      = 1'b0;
        proc_idx_next  = proc_idx_reg;
        chosen_next    = chosen_reg;
        prio_next      = prio_reg;
        done_next      = 1'b0;
        cur_note_next  = cur_note_reg;
        any_held_next  = any_held_reg;
        ram_we         = 1'b0;

        if (apb_write && (paddr == mnpt_pkg::ADDR_PRIORITY_SELECT))
        begin
            prio_next = pwdata[0];
        end

        // slot under evaluation, with this event's change applied
        slot_v = valid_reg[proc_idx_reg];
        eff_v  = slot_v;
        eff_n  = ram_rdata;
        if (!found_reg)
        begin
            if (mode_reg == mnpt_pkg::MODE_NOTE_ON)
            begin
                if (!slot_v)
                begin
                    eff_v = 1'b1;
                    eff_n = note_reg;
                end
            end
            else if (slot_v && (ram_rdata == note_reg))
            begin
                eff_v = 1'b0;
            end
        end

        // shared compare
        better = (prio_reg == mnpt_pkg::PRIO_HIGHEST) ? (eff_n > best_reg)
                                                      : (eff_n < best_reg);
        scan_any  = any_reg;
        scan_best = best_reg;
        if (eff_v && (!any_reg || better))
        begin
            scan_best = eff_n;
        end
        if (eff_v)
        begin
            scan_any = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next     = ST_SCAN;
                    mode_next      = mode;
                    note_next      = note_number;
                    found_next     = 1'b0;
                    any_next       = 1'b0;
                    best_next      = '0;
                    issue_idx_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (issue_idx_reg < CNT_W'(NOTE_SLOTS))
                begin
                    pend_next      = 1'b1;
                    proc_idx_next  = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (!found_reg && (eff_v != slot_v))
                    begin
                        found_next                   = 1'b1;
                        valid_next[proc_idx_reg]     = eff_v;
                        ram_we                       = eff_v;
                    end
                    any_next  = scan_any;
                    best_next = scan_best;
                    if (proc_idx_reg == IDX_W'(NOTE_SLOTS - 1))
                    begin
                        state_next    = ST_IDLE;
                        pend_next     = 1'b0;
                        done_next     = 1'b1;
                        any_held_next = scan_any;
                        if (scan_any)
                        begin
                            chosen_next   = scan_best;
                            cur_note_next = scan_best;
                        end
                        else
                        begin
                            cur_note_next = chosen_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < NOTE_SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            mode_reg      <= 1'b0;
            note_reg      <= '0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
            best_reg      <= '0;
            issue_idx_reg <= '0;
            pend_reg      <= 1'b0;
            proc_idx_reg  <= '0;
            chosen_reg    <= '0;
            prio_reg      <= mnpt_pkg::PRIO_HIGHEST;
            done_reg      <= 1'b0;
            cur_note_reg  <= '0;
            any_held_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            mode_reg      <= mode_next;
            note_reg      <= note_next;
            found_reg     <= found_next;
            any_reg       <= any_next;
            best_reg      <= best_next;
            issue_idx_reg <= issue_idx_next;
            pend_reg      <= pend_next;
            proc_idx_reg  <= proc_idx_next;
            chosen_reg    <= chosen_next;
            prio_reg      <= prio_next;
            done_reg      <= done_next;
            cur_note_reg  <= cur_note_next;
            any_held_reg  <= any_held_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign current_note = cur_note_reg;
    assign any_held     = any_held_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr == mnpt_pkg::ADDR_PRIORITY_SELECT)
                          ? {{(mnpt_pkg::APB_DATA_W-1){1'b0}}, prio_reg}
                          : '0;

endmodule

`default_nettype wire

/* sv/mnpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mnpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
